[sv/stt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

  localparam int KW_COUNT = 13;
  localparam int KW_BYTES = 8;
  localparam int Q_DEPTH = 4;
  localparam int QAW = $clog2(Q_DEPTH);

  localparam logic [5:0] K_STRING = 6'd33;
  localparam logic [5:0] K_NUMBER = 6'd34;
  localparam logic [5:0] K_IDENT  = 6'd35;
  localparam logic [5:0] K_END    = 6'd47;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_FLOAT     = 3'd1;
  localparam logic [2:0] E_STRING    = 3'd2;
  localparam logic [2:0] E_FORBIDDEN = 3'd3;
  localparam logic [2:0] E_DIGIT_ID  = 3'd4;

  localparam logic [1:0] TAG_DIGITS = 2'd0;
  localparam logic [1:0] TAG_TRUE   = 2'd1;
  localparam logic [1:0] TAG_FALSE  = 2'd2;

  // keyword text, first byte in the lowest bits
  localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
    64'("fi"), 64'("esle"), 64'("elihw"), 64'("rof"), 64'("tel"), 64'("eurt"),
    64'("eslaf"), 64'("nruter"), 64'("tnirp"), 64'("ssalc"), 64'("eunitnoc"),
    64'("kaerb"), 64'("cnuf")
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{
    16'd2, 16'd4, 16'd5, 16'd3, 16'd3, 16'd4, 16'd5, 16'd6, 16'd5, 16'd5, 16'd8,
    16'd5, 16'd4
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd36, 6'd37, 6'd38, 6'd39, 6'd40, K_NUMBER, K_NUMBER, 6'd41, 6'd42, 6'd43,
    6'd44, 6'd45, 6'd46
  };
  localparam logic [1:0] KW_TAG [KW_COUNT] = '{
    TAG_DIGITS, TAG_DIGITS, TAG_DIGITS, TAG_DIGITS, TAG_DIGITS, TAG_TRUE,
    TAG_FALSE, TAG_DIGITS, TAG_DIGITS, TAG_DIGITS, TAG_DIGITS, TAG_DIGITS,
    TAG_DIGITS
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [1:0]  tag;
    logic [2:0]  err;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

[sv/stt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module stt_front #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LINE_BITS = 16,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire logic         op_i,
  input  wire logic [7:0]   ch_i,
  output stt_pkg::push_t    push_o
);
  import stt_pkg::*;

  localparam int KB = KEYWORD_CHARS * 8;
  localparam int CW = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

  typedef enum logic [5:0] {
    S_EQ, S_PLUS, S_PLUSPLUS, S_PLUSEQ, S_MINUS, S_MINUSMINUS, S_MINUSEQ,
    S_SLASH, S_SLASHEQ, S_STAR, S_STAREQ, S_MOD, S_MODEQ, S_LBRACE, S_RBRACE,
    S_LPAREN, S_RPAREN, S_OR, S_OROR, S_AND, S_ANDAND, S_EQEQ, S_LT, S_GT,
    S_LTEQ, S_GTEQ, S_NOT, S_NOTEQ, S_SEMI, S_POINT, S_COMMA, S_COLON, S_QMARK,
    S_START, S_WS, S_LCOMM, S_BCOMM, S_BCOMMSTAR, S_BCOMMEND, S_INT, S_INTERR,
    S_FLOATERR, S_FLOAT, S_STRERR, S_STR, S_CHRERR, S_CHR, S_ID
  } state_e;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ids(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h09 || c == 8'h0a || c == " ";
  endfunction

  // returns {arc found, next state}
  function automatic logic [6:0] next_state(input state_e s, input logic [7:0] c);
    logic ok;
    state_e n;
    ok = 1'b1;
    n = S_START;
    case (s)
      S_START: begin
        case (c)
          "=": n = S_EQ;
          "+": n = S_PLUS;
          "-": n = S_MINUS;
          "/": n = S_SLASH;
          "*": n = S_STAR;
          "%": n = S_MOD;
          "{": n = S_LBRACE;
          "}": n = S_RBRACE;
          "(": n = S_LPAREN;
          ")": n = S_RPAREN;
          "|": n = S_OR;
          "&": n = S_AND;
          "<": n = S_LT;
          ">": n = S_GT;
          "!": n = S_NOT;
          ";": n = S_SEMI;
          ".": n = S_POINT;
          ",": n = S_COMMA;
          ":": n = S_COLON;
          "?": n = S_QMARK;
          8'h22: n = S_STRERR;
          8'h27: n = S_CHRERR;
          8'h09, 8'h0a, " ": n = S_WS;
          default: begin
            if (is_digit(c)) n = S_INT;
            else if (is_ids(c)) n = S_ID;
            else ok = 1'b0;
          end
        endcase
      end
      S_PLUS: begin
        if (c == "+") n = S_PLUSPLUS;
        else if (c == "=") n = S_PLUSEQ;
        else ok = 1'b0;
      end
      S_MINUS: begin
        if (c == "-") n = S_MINUSMINUS;
        else if (c == "=") n = S_MINUSEQ;
        else ok = 1'b0;
      end
      S_SLASH: begin
        if (c == "=") n = S_SLASHEQ;
        else if (c == "/") n = S_LCOMM;
        else if (c == "*") n = S_BCOMM;
        else ok = 1'b0;
      end
      S_STAR: begin n = S_STAREQ; ok = (c == "="); end
      S_MOD:  begin n = S_MODEQ;  ok = (c == "="); end
      S_OR:   begin n = S_OROR;   ok = (c == "|"); end
      S_AND:  begin n = S_ANDAND; ok = (c == "&"); end
      S_EQ:   begin n = S_EQEQ;   ok = (c == "="); end
      S_LT:   begin n = S_LTEQ;   ok = (c == "="); end
      S_GT:   begin n = S_GTEQ;   ok = (c == "="); end
      S_NOT:  begin n = S_NOTEQ;  ok = (c == "="); end
      S_LCOMM: begin n = S_LCOMM; ok = (c != 8'h0a); end
      S_BCOMM: n = (c == "*") ? S_BCOMMSTAR : S_BCOMM;
      S_BCOMMSTAR: n = (c == "/") ? S_BCOMMEND : S_BCOMM;
      S_INT: begin
        if (is_ids(c)) n = S_INTERR;
        else if (is_digit(c)) n = S_INT;
        else if (c == ".") n = S_FLOATERR;
        else ok = 1'b0;
      end
      S_FLOATERR, S_FLOAT: begin n = S_FLOAT; ok = is_digit(c); end
      S_STRERR: begin
        if (c == 8'h22) n = S_STR;
        else begin n = S_STRERR; ok = (c != 8'h0a); end
      end
      S_CHRERR: begin
        if (c == 8'h27) n = S_CHR;
        else begin n = S_CHRERR; ok = (c != 8'h0a); end
      end
      S_ID: begin n = S_ID; ok = is_ids(c) || is_digit(c); end
      S_WS: begin n = S_WS; ok = is_ws(c); end
      default: ok = 1'b0;
    endcase
    return {ok, n};
  endfunction

  state_e                 state_q, state_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [15:0]            len_q, len_d;
  logic [KB-1:0]          kbuf_q, kbuf_d;
  logic                   halted_q, halted_d;
  push_t                  push_q, push_d;

  logic [6:0]    ns1, ns2;
  logic          tok_ok;
  logic [2:0]    close_err;
  res_t          tok, end_res;
  logic [CW-1:0] colx, lenx;
  logic [15:0]   tok_col, line16, col16;
  logic          do_consume;
  state_e        base_state;
  logic [15:0]   base_len;
  logic [KB-1:0] base_kbuf;

  assign ns1 = next_state(state_q, ch_i);
  assign ns2 = next_state(S_START, ch_i);
  assign colx = CW'(col_q);
  assign lenx = CW'(len_q);
  assign tok_col = (colx >= lenx) ? 16'(colx - lenx) : 16'd0;
  assign line16 = 16'(line_q);
  assign col16 = 16'(col_q);

  always_comb begin
    tok_ok = 1'b0;
    close_err = E_NONE;
    tok = '0;
    tok.line = line16;
    tok.column = tok_col;
    tok.length = len_q;
    if (state_q <= S_QMARK) begin
      tok_ok = 1'b1;
      tok.kind = 6'(state_q);
    end else begin
      case (state_q)
        S_STR, S_CHR: begin tok_ok = 1'b1; tok.kind = K_STRING; end
        S_INT, S_FLOAT: begin tok_ok = 1'b1; tok.kind = K_NUMBER; end
        S_ID: begin
          tok_ok = 1'b1;
          tok.kind = K_IDENT;
          for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (len_q == KW_LEN[i] && kbuf_q == KB'(KW_TEXT[i])) begin
              tok.kind = KW_KIND[i];
              tok.tag = KW_TAG[i];
            end
          end
        end
        S_FLOATERR: close_err = E_FLOAT;
        S_STRERR, S_CHRERR: close_err = E_STRING;
        S_START: close_err = E_FORBIDDEN;
        S_INTERR: close_err = E_DIGIT_ID;
        default: close_err = E_NONE;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    line_d = line_q;
    col_d = col_q;
    len_d = len_q;
    kbuf_d = kbuf_q;
    halted_d = halted_q;
    push_d = '0;
    end_res = '0;
    end_res.kind = K_END;
    end_res.line = line16;
    end_res.column = col16;
    end_res.last = 1'b1;
    do_consume = 1'b0;
    base_state = state_q;
    base_len = len_q;
    base_kbuf = kbuf_q;
    if (fire_i) begin
      if (op_i) begin
        if (!halted_q) begin
          end_res.err = close_err;
          if (tok_ok) begin
            push_d.cnt = 2'd2;
            push_d.r0 = tok;
            push_d.r1 = end_res;
          end else begin
            push_d.cnt = 2'd1;
            push_d.r0 = end_res;
          end
        end
        state_d = S_START;
        line_d = LINE_BITS'(1);
        col_d = COLUMN_BITS'(1);
        len_d = '0;
        kbuf_d = '0;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        if (ns1[6]) begin
          do_consume = 1'b1;
        end else if (close_err != E_NONE) begin
          end_res.err = close_err;
          push_d.cnt = 2'd1;
          push_d.r0 = end_res;
          halted_d = 1'b1;
        end else begin
          end_res.err = E_FORBIDDEN;
          if (tok_ok) begin
            push_d.r0 = tok;
            push_d.r1 = end_res;
          end else begin
            push_d.r0 = end_res;
          end
          if (ns2[6]) begin
            do_consume = 1'b1;
            base_state = S_START;
            base_len = '0;
            base_kbuf = '0;
            push_d.cnt = {1'b0, tok_ok};
          end else begin
            push_d.cnt = tok_ok ? 2'd2 : 2'd1;
            halted_d = 1'b1;
          end
        end
      end
    end
    if (do_consume) begin
      state_d = state_e'(ns1[6] ? ns1[5:0] : ns2[5:0]);
      len_d = base_len;
      kbuf_d = base_kbuf;
      if (base_state != S_WS) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
          if (base_len == 16'(i)) kbuf_d[i*8 +: 8] = ch_i;
        end
        if (base_len != 16'hffff) len_d = base_len + 16'd1;
      end
      if (ch_i == 8'h0a) begin
        if (line_q != '1) line_d = line_q + LINE_BITS'(1);
        col_d = COLUMN_BITS'(1);
      end else if (col_q != '1) begin
        col_d = col_q + COLUMN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      line_q <= LINE_BITS'(1);
      col_q <= COLUMN_BITS'(1);
      len_q <= '0;
      kbuf_q <= '0;
      halted_q <= 1'b0;
      push_q <= '0;
    end else begin
      state_q <= state_d;
      line_q <= line_d;
      col_q <= col_d;
      len_q <= len_d;
      kbuf_q <= kbuf_d;
      halted_q <= halted_d;
      push_q <= push_d;
    end
  end

  assign push_o = push_q;

endmodule
`default_nettype wire

[sv/stt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module stt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  stt_pkg::push_t     push_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output stt_pkg::res_t      head_o
);
  import stt_pkg::*;

  res_t           mem_q [Q_DEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   count_q;
  logic           pop;

  assign pop = valid_o && ready_i;
  assign valid_o = count_q != '0;
  assign head_o = mem_q[rptr_q];
  // two entries free, counting words still held in the front register, before this cycle's pop
  assign room_o = (count_q + (QAW + 1)'(push_i.cnt)) <= (QAW + 1)'(Q_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wptr_q + QAW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      wptr_q <= wptr_q + QAW'(push_i.cnt);
      if (pop) rptr_q <= rptr_q + QAW'(1);
      count_q <= count_q + (QAW + 1)'(push_i.cnt) - (QAW + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

[sv/source_text_tokenizer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Source text lexer taking one byte per cycle, or an end mark on tuser. A
// front stage walks the character automaton, closes tokens, matches keywords
// and keeps line, column and length counters; it emits zero, one or two result
// words per input word into a four-entry queue that feeds the output. A result
// passes through the front register and the queue memory. The front sustains
// one input word per cycle; it stalls only while the queue, counting the words
// still held in the front register, has fewer than two free entries, so words
// that yield two results, or a stalled output, slow the input to the output
// rate of one result per cycle.
module source_text_tokenizer_top #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LINE_BITS = 16,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // ch
  input  wire logic        s_axis_tuser_i,  // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,  // line, column, length, literal_tag, error_code
  output logic [5:0]       m_axis_tuser_o,  // kind
  output logic             m_axis_tlast_o
);
  import stt_pkg::*;

  push_t push;
  res_t  head;
  logic  room;

  assign s_axis_tready_o = room;

  stt_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .LINE_BITS(LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .fire_i(s_axis_tvalid_i && room),
    .op_i(s_axis_tuser_i),
    .ch_i(s_axis_tdata_i),
    .push_o(push)
  );

  stt_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .room_o(room),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .head_o(head)
  );

  assign m_axis_tdata_o = {3'b000, head.err, head.tag, head.length, head.column, head.line};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule
`default_nettype wire

[sv/stt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module stt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o,
  input wire logic [5:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);
  import stt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == K_END)
    else $error("tlast on a non-end word");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == K_END |-> m_axis_tlast_o)
    else $error("end word without tlast");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:0] != 16'd0)
    else $error("line number zero");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= K_END)
    else $error("kind out of range");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o),
  .m_axis_tuser_o(m_axis_tuser_o),
  .m_axis_tlast_o(m_axis_tlast_o)
);
`default_nettype wire

[sim/source_text_tokenizer_checker.sv]
`timescale 1ns / 1ps
module source_text_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [55:0] m_data_i,
  input  logic [5:0]  m_user_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import stt_pkg::*;

  typedef enum logic [5:0] {
    ST_EQ, ST_PLUS, ST_PLUSPLUS, ST_PLUSEQ, ST_MINUS, ST_MINUSMINUS, ST_MINUSEQ,
    ST_SLASH, ST_SLASHEQ, ST_STAR, ST_STAREQ, ST_MOD, ST_MODEQ, ST_LBRACE,
    ST_RBRACE, ST_LPAREN, ST_RPAREN, ST_OR, ST_OROR, ST_AND, ST_ANDAND, ST_EQEQ,
    ST_LT, ST_GT, ST_LTEQ, ST_GTEQ, ST_NOT, ST_NOTEQ, ST_SEMI, ST_POINT,
    ST_COMMA, ST_COLON, ST_QMARK, ST_START, ST_WS, ST_LCOMM, ST_BCOMM,
    ST_BCOMMSTAR, ST_BCOMMEND, ST_INT, ST_INTERR, ST_FLOATERR, ST_FLOAT,
    ST_STRERR, ST_STR, ST_CHRERR, ST_CHR, ST_ID, ST_NONE
  } lex_state_e;

  lex_state_e  lex_state;
  logic [15:0] line_cnt, col_cnt, tok_len;
  logic [63:0] kw_buf;
  logic        stopped;
  res_t        token_q[$];

  assign pending_o = token_q.size();

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_id_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic lex_state_e first_state(logic [7:0] c);
    case (c)
      "=": return ST_EQ;     "+": return ST_PLUS;   "-": return ST_MINUS;
      "/": return ST_SLASH;  "*": return ST_STAR;   "%": return ST_MOD;
      "{": return ST_LBRACE; "}": return ST_RBRACE; "(": return ST_LPAREN;
      ")": return ST_RPAREN; "|": return ST_OR;     "&": return ST_AND;
      "<": return ST_LT;     ">": return ST_GT;     "!": return ST_NOT;
      ";": return ST_SEMI;   ".": return ST_POINT;  ",": return ST_COMMA;
      ":": return ST_COLON;  "?": return ST_QMARK;  "\"": return ST_STRERR;
      8'h27: return ST_CHRERR;
      8'h09, 8'h0a, " ": return ST_WS;
      default: ;
    endcase
    if (is_digit(c)) return ST_INT;
    if (is_id_start(c)) return ST_ID;
    return ST_NONE;
  endfunction

  function automatic lex_state_e advance(lex_state_e s, logic [7:0] c);
    case (s)
      ST_START: return first_state(c);
      ST_PLUS: return c == "+" ? ST_PLUSPLUS : (c == "=" ? ST_PLUSEQ : ST_NONE);
      ST_MINUS: return c == "-" ? ST_MINUSMINUS : (c == "=" ? ST_MINUSEQ : ST_NONE);
      ST_SLASH: begin
        if (c == "=") return ST_SLASHEQ;
        if (c == "/") return ST_LCOMM;
        if (c == "*") return ST_BCOMM;
        return ST_NONE;
      end
      ST_STAR: return c == "=" ? ST_STAREQ : ST_NONE;
      ST_MOD: return c == "=" ? ST_MODEQ : ST_NONE;
      ST_OR: return c == "|" ? ST_OROR : ST_NONE;
      ST_AND: return c == "&" ? ST_ANDAND : ST_NONE;
      ST_EQ: return c == "=" ? ST_EQEQ : ST_NONE;
      ST_LT: return c == "=" ? ST_LTEQ : ST_NONE;
      ST_GT: return c == "=" ? ST_GTEQ : ST_NONE;
      ST_NOT: return c == "=" ? ST_NOTEQ : ST_NONE;
      ST_LCOMM: return c != 8'h0a ? ST_LCOMM : ST_NONE;
      ST_BCOMM: return c != "*" ? ST_BCOMM : ST_BCOMMSTAR;
      ST_BCOMMSTAR: return c != "/" ? ST_BCOMM : ST_BCOMMEND;
      ST_INT: begin
        if (is_id_start(c)) return ST_INTERR;
        if (is_digit(c)) return ST_INT;
        if (c == ".") return ST_FLOATERR;
        return ST_NONE;
      end
      ST_FLOATERR, ST_FLOAT: return is_digit(c) ? ST_FLOAT : ST_NONE;
      ST_STRERR: begin
        if (c == "\"") return ST_STR;
        return c != 8'h0a ? ST_STRERR : ST_NONE;
      end
      ST_CHRERR: begin
        if (c == 8'h27) return ST_CHR;
        return c != 8'h0a ? ST_CHRERR : ST_NONE;
      end
      ST_ID: return (is_id_start(c) || is_digit(c)) ? ST_ID : ST_NONE;
      ST_WS: return (c == 8'h09 || c == 8'h0a || c == " ") ? ST_WS : ST_NONE;
      default: return ST_NONE;
    endcase
  endfunction

  function automatic res_t make_token(logic [5:0] kind, logic [15:0] len,
                                      logic [1:0] tag, logic [2:0] err, logic last);
    res_t r;
    r.kind = kind;
    r.line = line_cnt;
    r.column = col_cnt >= len ? col_cnt - len : 16'd0;
    r.length = len;
    r.tag = tag;
    r.err = err;
    r.last = last;
    return r;
  endfunction

  function automatic void add_expected(res_t r);
    token_q.insert(token_q.size(), r);
  endfunction

  // queues the closed token if any, returns its error code
  function automatic logic [2:0] close_token();
    logic [5:0] kind;
    logic [1:0] tag;
    kind = K_IDENT;
    tag = TAG_DIGITS;
    if (lex_state <= ST_QMARK) kind = 6'(lex_state);
    else if (lex_state == ST_STR || lex_state == ST_CHR) kind = K_STRING;
    else if (lex_state == ST_INT || lex_state == ST_FLOAT) kind = K_NUMBER;
    else if (lex_state == ST_ID) begin
      for (int i = 0; i < KW_COUNT; i++)
        if (kind == K_IDENT && tok_len == KW_LEN[i] && kw_buf == KW_TEXT[i]) begin
          kind = KW_KIND[i];
          tag = KW_TAG[i];
        end
    end
    else if (lex_state == ST_FLOATERR) return E_FLOAT;
    else if (lex_state == ST_STRERR || lex_state == ST_CHRERR) return E_STRING;
    else if (lex_state == ST_START) return E_FORBIDDEN;
    else if (lex_state == ST_INTERR) return E_DIGIT_ID;
    else return E_NONE;
    add_expected(make_token(kind, tok_len, tag, E_NONE, 1'b0));
    return E_NONE;
  endfunction

  function automatic void take_byte(logic [7:0] c, lex_state_e dst);
    if (lex_state != ST_WS) begin
      if (tok_len < KW_BYTES) kw_buf[tok_len*8 +: 8] = c;
      if (tok_len != 16'hffff) tok_len++;
    end
    if (c == 8'h0a) begin
      if (line_cnt != 16'hffff) line_cnt++;
      col_cnt = 16'd1;
    end else if (col_cnt != 16'hffff) begin
      col_cnt++;
    end
    lex_state = dst;
  endfunction

  function automatic void clear_all();
    lex_state = ST_START;
    line_cnt = 16'd1;
    col_cnt = 16'd1;
    tok_len = '0;
    kw_buf = '0;
    stopped = 1'b0;
  endfunction

  function automatic void lex_word(logic op, logic [7:0] c);
    logic [2:0] err;
    lex_state_e dst;
    if (op) begin
      if (!stopped) begin
        err = close_token();
        add_expected(make_token(K_END, '0, TAG_DIGITS, err, 1'b1));
      end
      clear_all();
      return;
    end
    if (stopped) return;
    dst = advance(lex_state, c);
    if (dst != ST_NONE) begin
      take_byte(c, dst);
      return;
    end
    err = close_token();
    if (err == E_NONE) begin
      lex_state = ST_START;
      tok_len = '0;
      kw_buf = '0;
      dst = first_state(c);
      if (dst != ST_NONE) begin
        take_byte(c, dst);
        return;
      end
      err = E_FORBIDDEN;
    end
    add_expected(make_token(K_END, '0, TAG_DIGITS, err, 1'b1));
    stopped = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_all();
      token_q.delete();
      fail_count_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) lex_word(s_user_i, s_data_i);
      if (m_valid_i && m_ready_i) begin
        if (token_q.size() == 0) begin
          $error("unexpected word kind %0d", m_user_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = token_q.pop_front();
          if (want.kind !== m_user_i || want.line !== m_data_i[15:0] ||
              want.column !== m_data_i[31:16] || want.length !== m_data_i[47:32] ||
              want.tag !== m_data_i[49:48] || want.err !== m_data_i[52:50] ||
              want.last !== m_last_i || m_data_i[55:53] !== 3'd0) begin
            if (want.kind !== m_user_i)
              $error("kind expected %0d actual %0d", want.kind, m_user_i);
            if (want.line !== m_data_i[15:0])
              $error("line expected %0d actual %0d", want.line, m_data_i[15:0]);
            if (want.column !== m_data_i[31:16])
              $error("column expected %0d actual %0d", want.column, m_data_i[31:16]);
            if (want.length !== m_data_i[47:32])
              $error("length expected %0d actual %0d", want.length, m_data_i[47:32]);
            if (want.tag !== m_data_i[49:48])
              $error("literal_tag expected %0d actual %0d", want.tag, m_data_i[49:48]);
            if (want.err !== m_data_i[52:50])
              $error("error_code expected %0d actual %0d", want.err, m_data_i[52:50]);
            if (want.last !== m_last_i)
              $error("last expected %0d actual %0d", want.last, m_last_i);
            if (m_data_i[55:53] !== 3'd0)
              $error("padding expected 0 actual %0d", m_data_i[55:53]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/source_text_tokenizer_top_tb.sv]
`timescale 1ns / 1ps
module source_text_tokenizer_top_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [55:0] m_data;
  logic [5:0]  m_user;
  logic        m_last;
  int          fail_count, pending;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          sent = 0;
  logic [7:0]  word_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  source_text_tokenizer_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  source_text_tokenizer_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .m_last_i(m_last), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #20ms;
    $display("source_text_tokenizer_top_tb: errors");
    $finish;
  end

  // output side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send(logic op, logic [7:0] c);
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= c;
    do @(posedge clk_i); while (!s_ready);
    sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
  endtask

  task automatic finish_stream();
    send(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic flush_queue();
    while (word_q.size() != 0) send(1'b0, word_q.pop_front());
  endtask

  function automatic void add_byte(logic [7:0] c);
    word_q.insert(word_q.size(), c);
  endfunction

  function automatic logic [7:0] any_letter();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      default: return "_";
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void push_token();
    string kw[13] = '{"if", "else", "while", "for", "let", "true", "false", "return",
                      "print", "class", "continue", "break", "func"};
    string ops[33] = '{"=", "+", "++", "+=", "-", "--", "-=", "/", "/=", "*", "*=",
                       "%", "%=", "{", "}", "(", ")", "|", "||", "&", "&&", "==", "<",
                       ">", "<=", ">=", "!", "!=", ";", ".", ",", ":", "?"};
    logic [7:0] c, q;
    case ($urandom_range(0, 19))
      0, 1, 2: push_text(kw[$urandom_range(0, 12)]);
      3, 4, 5: begin
        add_byte(any_letter());
        repeat ($urandom_range(0, 10))
          add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                                             : any_letter());
      end
      6, 7: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range("0", "9")));
      8: begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
        add_byte(".");
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
      end
      9, 10: begin
        q = $urandom_range(0, 1) ? "\"" : 8'h27;
        add_byte(q);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(0, 255));
          if (c != q && c != 8'h0a) add_byte(c);
        end
        add_byte(q);
      end
      11, 12, 13, 14: push_text(ops[$urandom_range(0, 32)]);
      15: begin
        push_text("//");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          if (c != 8'h0a) add_byte(c);
        end
        add_byte(8'h0a);
      end
      16: begin
        push_text("/*");
        repeat ($urandom_range(0, 6))
          add_byte($urandom_range(0, 2) == 0 ? "*" : 8'($urandom_range(0, 255)));
        push_text("*/");
      end
      17: add_byte(8'($urandom_range(0, 255)));
      18: case ($urandom_range(0, 2))
        0: push_text("7.");
        1: push_text("3x");
        default: push_text("\"ab\n");
      endcase
      default: push_text("x");
    endcase
    case ($urandom_range(0, 5))
      0: add_byte(" ");
      1: add_byte(8'h0a);
      2: add_byte(8'h09);
      3: push_text(" \n ");
      default: ;
    endcase
  endfunction

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stream, then each error kind and halted drop
    finish_stream();
    send_text("a 7.;");
    finish_stream();
    send_text("\"ab\n");
    send_text("zz");
    finish_stream();
    send(1'b0, 8'h00);
    finish_stream();
    send_text("1a ");
    finish_stream();
    send_text("x=true+false;continue iffy 'c' 12 3.5/**/*/* ** */");
    finish_stream();
    send_text("if else while for let return print class break func");
    finish_stream();
    send_text("+ ++ += - -- -= /= * *= % %= {}()| || & && == < > <= >= ! != .,:?");
    send_text("//c\n/* open");
    finish_stream();
    wait_drained();

    // long output stall while the input keeps offering words
    hold_req = 1'b1;
    repeat (40) push_token();
    flush_queue();
    finish_stream();
    wait_drained();

    // random token streams
    while (sent < 1700) begin
      if (sent > 1550) calm = 1'b1;
      repeat ($urandom_range(1, 30)) push_token();
      flush_queue();
      finish_stream();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("source_text_tokenizer_top_tb: clean");
    end else begin
      $display("source_text_tokenizer_top_tb: errors");
    end
    $finish;
  end

endmodule

[source_text_tokenizer_top.f]
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/source_text_tokenizer_top.sv
sv/stt_checker.sv
sim/source_text_tokenizer_checker.sv
sim/source_text_tokenizer_top_tb.sv
